@@ hdl/fbe_pkg.sv @@
// Shared command codes, byte constants and the queue entry type of the framebuffer engine.
package fbe_pkg;

    localparam logic [2:0] CMD_POINT   = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_BYTE    = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_REFRESH = 3'd4;

    localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD    = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
    localparam logic [7:0] TOP_BIT_MASK   = 8'h80;

    localparam int NBYTES_W = 13;

    // One classified command as it waits between the front and the back end.
    typedef struct packed {
        logic [2:0]          cmd;
        logic                ok;
        logic [7:0]          pos_x;
        logic [7:0]          pos_y;
        logic [7:0]          img_height;
        logic                pixel_mode;
        logic [7:0]          image_data;
        logic [NBYTES_W-1:0] n_bytes;
    } cmd_t;

endpackage

@@ hdl/mono_oled_framebuffer_engine.sv @@
// Top level of the page-organized monochrome OLED framebuffer engine.
//
//  channel  | dir | tdata                          | tuser          | tlast
//  ---------+-----+--------------------------------+----------------+-----------
//  s_*      | in  | x, y, width, height, mode, img | command        | -
//  m_*      | out | out_byte                       | is_data (DC)   | frame_end
//
//  A point is read, then written back; an image byte is read and written back once per page it
//  touches, one page or two. A refresh data byte is first read from the store; a command byte is not.
//  Clear writes one store byte per cycle through the single write port, and after reset the
//  same sweep runs with s_tready low. A two-beat command queue and the output register let input
//  and output stall independently.
module mono_oled_framebuffer_engine #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, img_width, img_height, pixel_mode, image_data
    input  logic [2:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tuser,   // is_data
    output logic        m_tlast
);

    import fbe_pkg::*;

    logic init_busy;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_data;
    cmd_t q_head;

    fbe_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    fbe_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    fbe_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hdl/fbe_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module fbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/fbe_queue.sv @@
// Short command queue that decouples the front end from the back end.
module fbe_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbe_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output fbe_pkg::cmd_t head
);

    import fbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/fbe_front.sv @@
// Front end: accepts input beats, checks bounds and sizes images, and queues the commands.
module fbe_front #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,
    input  logic [2:0]    s_tuser,
    input  logic          init_busy,
    input  logic          q_full,
    output logic          q_push,
    output fbe_pkg::cmd_t q_data
);

    import fbe_pkg::*;

    localparam int ROWS = PAGES * 8;

    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] img_width;
    logic [7:0] img_height;
    logic       pixel_mode;
    logic [7:0] image_data;
    logic [9:0] x_end;
    logic [9:0] y_end;
    logic [5:0] col_pages;
    logic       known_cmd;

    assign pos_x      = s_tdata[7:0];
    assign pos_y      = s_tdata[15:8];
    assign img_width  = s_tdata[23:16];
    assign img_height = s_tdata[31:24];
    assign pixel_mode = s_tdata[32];
    assign image_data = s_tdata[40:33];

    assign x_end     = {2'b00, pos_x} + {2'b00, img_width};
    assign y_end     = {2'b00, pos_y} + {2'b00, img_height};
    assign col_pages = 6'(({2'b00, img_height} + 10'd7) >> 3);

    // Unused command codes are taken off the bus and dropped here.
    assign known_cmd = (s_tuser inside {CMD_POINT, CMD_START, CMD_BYTE, CMD_CLEAR, CMD_REFRESH});

    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready && known_cmd;

    always_comb
    begin
        q_data            = '0;
        q_data.cmd        = s_tuser;
        q_data.pos_x      = pos_x;
        q_data.pos_y      = pos_y;
        q_data.img_height = img_height;
        q_data.pixel_mode = pixel_mode;
        q_data.image_data = image_data;
        q_data.n_bytes    = NBYTES_W'(col_pages) * NBYTES_W'(img_width);
        case (s_tuser)
            CMD_POINT:
            begin
                q_data.ok = ({2'b00, pos_x} < 10'(COLUMNS)) && ({2'b00, pos_y} < 10'(ROWS));
            end
            CMD_START:
            begin
                q_data.ok = (x_end <= 10'(COLUMNS)) && (y_end <= 10'(ROWS));
            end
            default:
            begin
                q_data.ok = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/fbe_back.sv @@
// Back end: executes queued commands on the page store and drives the refresh byte stream.
module fbe_back #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  fbe_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          init_busy,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    import fbe_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PT_WR  = 3'd1;
    localparam logic [2:0] ST_IMG_RD = 3'd2;
    localparam logic [2:0] ST_IMG_WR = 3'd3;
    localparam logic [2:0] ST_REF    = 3'd4;
    localparam logic [2:0] ST_CLR    = 3'd5;

    logic [2:0]          state_reg,       state_next;
    logic                init_reg,        init_next;
    logic [AW-1:0]       clr_addr_reg,    clr_addr_next;
    logic [8:0]          cursor_col_reg,  cursor_col_next;
    logic [7:0]          cursor_row_reg,  cursor_row_next;
    logic [7:0]          origin_row_reg,  origin_row_next;
    logic [7:0]          act_height_reg,  act_height_next;
    logic [NBYTES_W-1:0] bytes_left_reg,  bytes_left_next;
    logic                act_mode_reg,    act_mode_next;
    logic [AW-1:0]       pt_addr_reg,     pt_addr_next;
    logic [7:0]          pt_mask_reg,     pt_mask_next;
    logic                pt_set_reg,      pt_set_next;
    logic [7:0]          img_bits_reg,    img_bits_next;
    logic [3:0]          img_cnt_reg,     img_cnt_next;
    logic                img_wrap_reg,    img_wrap_next;
    logic [PW-1:0]       ref_page_reg,    ref_page_next;
    logic [8:0]          ref_off_reg,     ref_off_next;
    logic                ref_last_reg,    ref_last_next;
    logic                ovalid_reg,      ovalid_next;
    logic [7:0]          obyte_reg,       obyte_next;
    logic                odata_reg,       odata_next;
    logic                olast_reg,       olast_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic [AW-1:0] head_addr;
    logic [AW-1:0] img_addr;
    logic [AW-1:0] ref_addr;
    logic [7:0]    img_rem;
    logic [2:0]    row_lo;
    logic [3:0]    page_room;
    logic [3:0]    page_take;
    logic [7:0]    img_merged;
    logic [2:0]    bit_k;
    logic          ref_page_last;
    logic          ref_off_last;

    fbe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign init_busy = init_reg;
    assign out_free  = !ovalid_reg || m_tready;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = obyte_reg;
    assign m_tuser   = odata_reg;
    assign m_tlast   = olast_reg;

    // Column-major store: a column's pages sit next to each other, top page last.
    assign head_addr = AW'(int'(q_head.pos_x) * PAGES
                           + (PAGES - 1 - int'(q_head.pos_y[7:3])));
    assign img_addr  = AW'(int'(cursor_col_reg) * PAGES
                           + (PAGES - 1 - int'(cursor_row_reg[7:3])));
    assign ref_addr  = AW'((int'(ref_off_reg) - 3) * PAGES + int'(ref_page_reg));

    assign img_rem   = 8'(origin_row_reg + act_height_reg - cursor_row_reg);
    assign row_lo    = cursor_row_reg[2:0];
    assign page_room = 4'd8 - {1'b0, row_lo};
    assign page_take = (img_cnt_reg < page_room) ? img_cnt_reg : page_room;

    assign ref_page_last = (ref_page_reg == PW'(PAGES - 1));
    assign ref_off_last  = (ref_off_reg == 9'(COLUMNS + 2));

    // Pixels of the current byte that land in this page, merged over the old contents.
    always_comb
    begin
        img_merged = ram_rdata;
        bit_k      = '0;
        for (int r = 0; r < 8; r++)
        begin
            bit_k = 3'(r) - row_lo;
            if ((3'(r) >= row_lo) && ({1'b0, bit_k} < img_cnt_reg))
            begin
                img_merged[7 - r] = img_bits_reg[3'd7 - bit_k] ? act_mode_reg : !act_mode_reg;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        clr_addr_next   = clr_addr_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        origin_row_next = origin_row_reg;
        act_height_next = act_height_reg;
        bytes_left_next = bytes_left_reg;
        act_mode_next   = act_mode_reg;
        pt_addr_next    = pt_addr_reg;
        pt_mask_next    = pt_mask_reg;
        pt_set_next     = pt_set_reg;
        img_bits_next   = img_bits_reg;
        img_cnt_next    = img_cnt_reg;
        img_wrap_next   = img_wrap_reg;
        ref_page_next   = ref_page_reg;
        ref_off_next    = ref_off_reg;
        ref_last_next   = ref_last_reg;
        ovalid_next     = ovalid_reg && !m_tready;
        obyte_next      = obyte_reg;
        odata_next      = odata_reg;
        olast_next      = olast_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = head_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.cmd)
                        CMD_POINT:
                        begin
                            q_pop = 1'b1;
                            if (q_head.ok)
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = head_addr;
                                pt_addr_next = head_addr;
                                pt_mask_next = TOP_BIT_MASK >> q_head.pos_y[2:0];
                                pt_set_next  = q_head.pixel_mode;
                                state_next   = ST_PT_WR;
                            end
                        end
                        CMD_START:
                        begin
                            q_pop           = 1'b1;
                            bytes_left_next = '0;
                            if (q_head.ok)
                            begin
                                cursor_col_next = {1'b0, q_head.pos_x};
                                cursor_row_next = q_head.pos_y;
                                origin_row_next = q_head.pos_y;
                                act_height_next = q_head.img_height;
                                act_mode_next   = q_head.pixel_mode;
                                bytes_left_next = q_head.n_bytes;
                            end
                        end
                        CMD_BYTE:
                        begin
                            q_pop = 1'b1;
                            if (bytes_left_reg != '0)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = img_addr;
                                img_bits_next = q_head.image_data;
                                img_cnt_next  = (img_rem >= 8'd8) ? 4'd8 : img_rem[3:0];
                                img_wrap_next = (img_rem <= 8'd8);
                                state_next    = ST_IMG_WR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            q_pop         = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLR;
                        end
                        CMD_REFRESH:
                        begin
                            if (ref_off_reg < 9'd3)
                            begin
                                if (out_free)
                                begin
                                    q_pop       = 1'b1;
                                    ovalid_next = 1'b1;
                                    odata_next  = 1'b0;
                                    olast_next  = 1'b0;
                                    case (ref_off_reg[1:0])
                                        2'd0:    obyte_next = PAGE_ADDR_BASE + 8'(ref_page_reg);
                                        2'd1:    obyte_next = COL_LOW_CMD;
                                        default: obyte_next = COL_HIGH_CMD;
                                    endcase
                                    ref_off_next = 9'(ref_off_reg + 1'b1);
                                end
                            end
                            else
                            begin
                                q_pop         = 1'b1;
                                ram_re        = 1'b1;
                                ram_raddr     = ref_addr;
                                ref_last_next = ref_page_last && ref_off_last;
                                state_next    = ST_REF;
                                if (ref_off_last)
                                begin
                                    ref_off_next  = '0;
                                    ref_page_next = ref_page_last ? '0 : PW'(ref_page_reg + 1'b1);
                                end
                                else
                                begin
                                    ref_off_next = 9'(ref_off_reg + 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_PT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pt_addr_reg;
                ram_wdata  = pt_set_reg ? (ram_rdata | pt_mask_reg) : (ram_rdata & ~pt_mask_reg);
                state_next = ST_IDLE;
            end
            ST_IMG_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = img_addr;
                state_next = ST_IMG_WR;
            end
            ST_IMG_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = img_addr;
                ram_wdata = img_merged;
                if (img_cnt_reg == page_take)
                begin
                    // The byte is done: either move down by eight rows or wrap to the next column.
                    bytes_left_next = NBYTES_W'(bytes_left_reg - 1'b1);
                    state_next      = ST_IDLE;
                    if (img_wrap_reg)
                    begin
                        cursor_row_next = origin_row_reg;
                        cursor_col_next = 9'(cursor_col_reg + 1'b1);
                    end
                    else
                    begin
                        cursor_row_next = 8'(cursor_row_reg + {4'd0, page_take});
                    end
                end
                else
                begin
                    // The byte crosses a page boundary; the remaining pixels go to the next page.
                    cursor_row_next = 8'(cursor_row_reg + {4'd0, page_take});
                    img_bits_next   = img_bits_reg << page_take;
                    img_cnt_next    = 4'(img_cnt_reg - page_take);
                    state_next      = ST_IMG_RD;
                end
            end
            ST_REF:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = ram_rdata;
                    odata_next  = 1'b1;
                    olast_next  = ref_last_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = AW'(clr_addr_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            init_reg       <= 1'b1;
            clr_addr_reg   <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            origin_row_reg <= '0;
            act_height_reg <= '0;
            bytes_left_reg <= '0;
            act_mode_reg   <= 1'b1;
            img_cnt_reg    <= '0;
            img_wrap_reg   <= 1'b0;
            ref_page_reg   <= '0;
            ref_off_reg    <= '0;
            ref_last_reg   <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            clr_addr_reg   <= clr_addr_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            origin_row_reg <= origin_row_next;
            act_height_reg <= act_height_next;
            bytes_left_reg <= bytes_left_next;
            act_mode_reg   <= act_mode_next;
            img_cnt_reg    <= img_cnt_next;
            img_wrap_reg   <= img_wrap_next;
            ref_page_reg   <= ref_page_next;
            ref_off_reg    <= ref_off_next;
            ref_last_reg   <= ref_last_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_addr_reg  <= pt_addr_next;
        pt_mask_reg  <= pt_mask_next;
        pt_set_reg   <= pt_set_next;
        img_bits_reg <= img_bits_next;
        obyte_reg    <= obyte_next;
        odata_reg    <= odata_next;
        olast_reg    <= olast_next;
    end

    a_no_pop_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !q_pop)
        else $error("command taken from the queue during the power-up clear");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and written in the same cycle");

    a_ref_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        ref_off_reg <= 9'(COLUMNS + 2))
        else $error("refresh offset ran past the end of a page");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg) |-> odata_reg)
        else $error("frame end flagged on a command byte");

    a_image_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IMG_WR) |-> (bytes_left_reg != '0))
        else $error("image byte written with no image active");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the page-organized OLED framebuffer engine and its refresh stream.
`timescale 1ns / 1ps

module testbench;

    import fbe_pkg::*;

    localparam int COLUMNS        = 128;
    localparam int PAGES          = 8;
    localparam int ROWS           = PAGES * 8;
    localparam int STORE_SIZE     = COLUMNS * PAGES;
    localparam int PAGE_LEN       = COLUMNS + 3;
    localparam int FRAME_LEN      = PAGES * PAGE_LEN;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES  = 1200;
    localparam int RX_HOLD_CYCLES = 400;

    localparam logic [2:0] CMD_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } panel_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // pos_x, pos_y, img_width, img_height, pixel_mode, image_data
    logic [2:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tuser;   // is_data
    logic        m_tlast;   // frame_end

    // Mirror of the engine state.
    logic [7:0]  shadow_fb [STORE_SIZE];
    int          draw_col;
    int          draw_row;
    int          draw_origin;
    int          draw_height;
    int          draw_bytes_left;
    logic        draw_mode;
    int          scan_pos;

    panel_beat_t pending_beats [$];

    int          mismatches;
    int          items_sent;
    int          beats_checked;
    int          frames_seen;
    int          clears_sent;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          rx_hold_req;

    mono_oled_framebuffer_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > TIMEOUT_CYCLES)
            begin
                $display("%0t: timeout with %0d beats still expected", $time,
                         pending_beats.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic void plot_pixel(int x, int y, logic on);
        int         idx;
        logic [7:0] mask;
        if (x < COLUMNS && y < ROWS)
        begin
            idx  = x * PAGES + (PAGES - 1 - y / 8);
            mask = TOP_BIT_MASK >> (y % 8);
            if (on)
                shadow_fb[idx] = shadow_fb[idx] | mask;
            else
                shadow_fb[idx] = shadow_fb[idx] & ~mask;
        end
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_fb[i])
            shadow_fb[i] = 8'h00;
    endfunction

    // Applies one accepted command to the mirror and queues the panel beat it produces.
    function automatic void model_command(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                                          logic [7:0] w, logic [7:0] h, logic mode,
                                          logic [7:0] data);
        int          page;
        int          offset;
        logic        wrapped;
        panel_beat_t beat;
        case (cmd)
            CMD_POINT:
                plot_pixel(x, y, mode);
            CMD_START:
            begin
                // A rejected start still cancels whatever image was in progress.
                draw_bytes_left = 0;
                if (int'(x) + int'(w) <= COLUMNS && int'(y) + int'(h) <= ROWS)
                begin
                    draw_col        = x;
                    draw_row        = y;
                    draw_origin     = y;
                    draw_height     = h;
                    draw_mode       = mode;
                    draw_bytes_left = ((int'(h) + 7) / 8) * int'(w);
                end
            end
            CMD_BYTE:
            begin
                if (draw_bytes_left != 0)
                begin
                    wrapped = 1'b0;
                    for (int k = 0; k < 8; k++)
                    begin
                        if (!wrapped)
                        begin
                            plot_pixel(draw_col, draw_row, data[7 - k] ? draw_mode : ~draw_mode);
                            draw_row++;
                            if (draw_row - draw_origin >= draw_height)
                            begin
                                draw_row = draw_origin;
                                draw_col++;
                                wrapped  = 1'b1;
                            end
                        end
                    end
                    draw_bytes_left--;
                end
            end
            CMD_CLEAR:
                clear_shadow();
            CMD_REFRESH:
            begin
                page   = scan_pos / PAGE_LEN;
                offset = scan_pos % PAGE_LEN;
                beat.is_data = 1'b0;
                case (offset)
                    0:       beat.out_byte = 8'(PAGE_ADDR_BASE + page);
                    1:       beat.out_byte = COL_LOW_CMD;
                    2:       beat.out_byte = COL_HIGH_CMD;
                    default:
                    begin
                        beat.out_byte = shadow_fb[(offset - 3) * PAGES + page];
                        beat.is_data  = 1'b1;
                    end
                endcase
                beat.frame_end = (scan_pos == FRAME_LEN - 1);
                scan_pos       = beat.frame_end ? 0 : scan_pos + 1;
                pending_beats.push_back(beat);
            end
            default:
                ;
        endcase
    endfunction

    // Offers one command from a falling edge and returns at the rising edge that takes it.
    task automatic send_cmd(input logic [2:0] cmd, input int x, input int y, input int w,
                            input int h, input int mode, input int data);
        logic [7:0] x_bits;
        logic [7:0] y_bits;
        logic [7:0] w_bits;
        logic [7:0] h_bits;
        logic       mode_bit;
        logic [7:0] data_bits;
        x_bits    = 8'(x);
        y_bits    = 8'(y);
        w_bits    = 8'(w);
        h_bits    = 8'(h);
        mode_bit  = mode[0];
        data_bits = 8'(data);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {7'd0, data_bits, mode_bit, h_bits, w_bits, y_bits, x_bits};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        model_command(cmd, x_bits, y_bits, w_bits, h_bits, mode_bit, data_bits);
        items_sent++;
        if (cmd == CMD_CLEAR)
            clears_sent++;
    endtask

    task automatic refresh_burst(input int count);
        for (int i = 0; i < count; i++)
            send_cmd(CMD_REFRESH, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(1), $urandom_range(255));
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
    endtask

    // Corners, off-screen points, image wrap, rejected and empty images, stray bytes.
    task automatic test_directed();
        send_cmd(CMD_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_POINT, COLUMNS - 1, ROWS - 1, 8'd0, 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_POINT, COLUMNS, 8'd5, 8'd0, 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_POINT, 8'd5, ROWS, 8'd0, 8'd0, 1'b1, 8'h00);
        send_cmd(CMD_POINT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_cmd(CMD_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00);
        send_cmd(CMD_POINT, 8'd3, 8'd7, 8'd0, 8'd0, 1'b1, 8'h00);
        // Short image in the bottom-right corner: each byte wraps after six rows.
        send_cmd(CMD_START, COLUMNS - 2, ROWS - 6, 8'd2, 8'd6, 1'b1, 8'h00);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'hFF);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'hA5);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h3C);
        send_cmd(CMD_START, COLUMNS - 1, 8'd0, 8'hFF, 8'd1, 1'b1, 8'h00);
        send_cmd(CMD_START, 8'd0, ROWS - 4, 8'd1, 8'hFF, 1'b1, 8'h00);
        send_cmd(CMD_START, 8'd20, 8'd20, 8'd0, 8'd9, 1'b1, 8'h00);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hFF);
        send_cmd(CMD_START, 8'd10, 8'd5, 8'd1, 8'd10, 1'b0, 8'h00);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'h0F);
        // This start lands before the previous image is finished and replaces it.
        send_cmd(CMD_START, 8'd40, 8'd30, 8'd1, 8'd8, 1'b1, 8'h00);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'h81);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hC3);
        for (int c = int'(CMD_REFRESH) + 1; c <= int'(CMD_LAST); c++)
            send_cmd(3'(c), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        refresh_burst(3);
    endtask

    // Finishing the current frame reads the rest of the store and crosses the frame end once.
    task automatic test_frame_readout();
        refresh_burst(FRAME_LEN - scan_pos + 4);
    endtask

    task automatic test_clear_midframe();
        send_cmd(CMD_START, 8'd60, 8'd10, 8'd4, 8'd12, 1'b1, 8'h00);
        send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'hF0);
        send_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00);
        // The image survives the clear, so the remaining bytes still draw.
        for (int i = 0; i < 7; i++)
            send_cmd(CMD_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, $urandom_range(255));
        refresh_burst(40);
    endtask

    task automatic test_random_mix(input int n_items);
        int   done_items;
        int   pick;
        int   w;
        int   h;
        int   nbytes;
        int   burst;
        done_items = 0;
        while (done_items < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                if ($urandom_range(9) == 0)
                begin
                    h = $urandom_range(1, ROWS);
                    w = $urandom_range(1, 4);
                end
                else if ($urandom_range(9) == 0)
                begin
                    h = $urandom_range(1, 8);
                    w = $urandom_range(1, COLUMNS);
                end
                else
                begin
                    h = $urandom_range(1, 16);
                    w = $urandom_range(1, 12);
                end
                send_cmd(CMD_START, $urandom_range(0, COLUMNS - w), $urandom_range(0, ROWS - h),
                         w, h, $urandom_range(1), $urandom_range(255));
                nbytes = ((h + 7) / 8) * w;
                // Now and then an image is cut short and left for the next start.
                if ($urandom_range(19) == 0)
                    nbytes = $urandom_range(0, nbytes);
                for (int k = 0; k < nbytes; k++)
                begin
                    if ($urandom_range(15) == 0)
                        refresh_burst(1);
                    send_cmd(CMD_BYTE, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255), $urandom_range(1),
                             $urandom_range(255));
                end
                done_items += 1 + nbytes;
            end
            else if (pick < 55)
            begin
                if ($urandom_range(4) == 0)
                    send_cmd(CMD_POINT, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255), $urandom_range(1),
                             $urandom_range(255));
                else
                    send_cmd(CMD_POINT, $urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1),
                             $urandom_range(255), $urandom_range(255), $urandom_range(1),
                             $urandom_range(255));
                done_items++;
            end
            else if (pick < 85)
            begin
                burst = $urandom_range(1, 24);
                refresh_burst(burst);
                done_items += burst;
            end
            else if (pick < 87)
            begin
                send_cmd(CMD_CLEAR, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(1), $urandom_range(255));
                done_items++;
            end
            else
            begin
                // Any code with any fields: stray bytes, oversized starts, unused codes.
                send_cmd(3'($urandom_range(int'(CMD_LAST))), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255), $urandom_range(255),
                         $urandom_range(1), $urandom_range(255));
                done_items++;
            end
        end
    endtask

    // The panel side holds off while refresh steps keep coming, so the input stalls.
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        refresh_burst(24);
        wait_until_drained();
    endtask

    initial
    begin : panel_side
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES)
                    @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_output
        panel_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (m_tlast)
                frames_seen++;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat byte=%h dc=%b last=%b", $time,
                         m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h", $time, want.out_byte, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.is_data)
                begin
                    $display("%0t: is_data expected %b got %b", $time, want.is_data, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %b got %b", $time, want.frame_end, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_POINT;
        mismatches      = 0;
        items_sent      = 0;
        beats_checked   = 0;
        frames_seen     = 0;
        clears_sent     = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rx_hold_req     = 1'b0;
        clear_shadow();
        draw_col        = 0;
        draw_row        = 0;
        draw_origin     = 0;
        draw_height     = 0;
        draw_bytes_left = 0;
        draw_mode       = 1'b1;
        scan_pos        = 0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_clear_midframe();
        test_random_mix(40);
        test_backpressure();

        tx_idle_pct  = 73;
        rx_stall_pct = 0;
        test_random_mix(40);

        tx_idle_pct  = 0;
        rx_stall_pct = 73;
        test_random_mix(40);

        tx_idle_pct  = 34;
        rx_stall_pct = 34;
        test_random_mix(40);
        test_frame_readout();
        test_backpressure();

        wait_until_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Sent %0d commands including %0d clears; checked %0d panel beats over %0d frames.",
                 items_sent, clears_sent, beats_checked, frames_seen);
        $display("Idle patterns: none, sender 73%%, receiver 73%%, both 34%%, plus long holds.");
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fbe_pkg.sv
hdl/fbe_ram.sv
hdl/fbe_queue.sv
hdl/fbe_front.sv
hdl/fbe_back.sv
hdl/mono_oled_framebuffer_engine.sv
bench/testbench.sv
